// File: hdl/dtq_pkg.sv
// Shared constants and types for the drop-tail feedback-stamp queue.
`default_nettype none
package dtq_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 256;

    localparam logic [1:0] OP_DATA     = 2'd0;
    localparam logic [1:0] OP_FEEDBACK = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [7:0] BUFFER_SIZE_RESET = 8'd200;

    // One stored packet.
    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] ticks;
        logic [15:0] remain;
        logic        fb;
    } t_slot;

    // One classified request handed from front to back.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] tag;
        logic [15:0] ticks;
        logic [15:0] remain;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic        sent;
        logic [15:0] sent_tag;
        logic        sent_is_feedback;
        logic [15:0] sent_remaining;
        logic        dropped;
        logic        overflow;
        logic [31:0] drop_total;
        logic [8:0]  queue_length;
    } t_result;

endpackage
`default_nettype wire

// File: hdl/dtq_if.sv
// Request and result channel interfaces of the drop-tail feedback-stamp queue.
`default_nettype none
interface dtq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] packet_tag;
    logic [15:0] service_ticks;
    logic [15:0] remaining_buffer;

    modport source (
        output valid, opcode, packet_tag, service_ticks, remaining_buffer,
        input  ready
    );
    modport sink (
        input  valid, opcode, packet_tag, service_ticks, remaining_buffer,
        output ready
    );
endinterface

interface dtq_res_if;
    logic        valid;
    logic        ready;
    logic        sent;
    logic [15:0] sent_tag;
    logic        sent_is_feedback;
    logic [15:0] sent_remaining;
    logic        dropped;
    logic        overflow;
    logic [31:0] drop_total;
    logic [8:0]  queue_length;

    modport source (
        output valid, sent, sent_tag, sent_is_feedback, sent_remaining, dropped,
               overflow, drop_total, queue_length,
        input  ready
    );
    modport sink (
        input  valid, sent, sent_tag, sent_is_feedback, sent_remaining, dropped,
               overflow, drop_total, queue_length,
        output ready
    );
endinterface
`default_nettype wire

// File: hdl/dtq_front.sv
// Front end: accepts requests, classifies them and buffers them in a two-entry queue.
`default_nettype none
module dtq_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    dtq_req_if.sink            i_req,
    output logic               o_cmd_valid,
    output dtq_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_pop
);
    import dtq_pkg::*;

    t_cmd       r_q [0:1];
    logic       r_wr_idx, n_wr_idx;
    logic       r_rd_idx, n_rd_idx;
    logic [1:0] r_fill,   n_fill;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;

    assign i_req.ready = (r_fill != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_cmd_pop && (r_fill != 2'd0);

    // Classify: unused opcode codes collapse to a no-op request.
    always_comb begin
        w_cmd.tag    = i_req.packet_tag;
        w_cmd.ticks  = i_req.service_ticks;
        w_cmd.remain = i_req.remaining_buffer;
        case (i_req.opcode)
            OP_DATA:     w_cmd.kind = OP_DATA;
            OP_FEEDBACK: w_cmd.kind = OP_FEEDBACK;
            OP_TICK:     w_cmd.kind = OP_TICK;
            default:     w_cmd.kind = OP_UNUSED;
        endcase
    end

    always_comb begin
        n_wr_idx = w_push ? ~r_wr_idx : r_wr_idx;
        n_rd_idx = w_pop  ? ~r_rd_idx : r_rd_idx;
        n_fill   = r_fill + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_idx] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_fill   <= n_fill;
        end
    end

    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rd_idx];

endmodule
`default_nettype wire

// File: hdl/dtq_back.sv
// Back end: packet store, drop and stamp logic, server countdown and result register.
`default_nettype none
module dtq_back #(
    parameter int unsigned QUEUE_DEPTH = dtq_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [7:0]    i_cfg_wdata,
    input  wire logic          i_cmd_valid,
    input  dtq_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    dtq_res_if.source          o_res
);
    import dtq_pkg::*;

    localparam int unsigned AW   = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned CMPW = (CW > 8) ? CW : 8;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_SERVE = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    t_slot          r_mem [0:QUEUE_DEPTH-1];
    t_slot          r_rd_slot;

    logic [1:0]     r_state,      n_state;
    logic [AW-1:0]  r_head,       n_head;
    logic [AW-1:0]  r_tail,       n_tail;
    logic [CW-1:0]  r_count,      n_count;
    logic           r_fb_pending, n_fb_pending;
    logic [CW-1:0]  r_fb_pos,     n_fb_pos;
    logic [31:0]    r_drop,       n_drop;
    logic [15:0]    r_busy,       n_busy;
    logic [7:0]     r_bs;
    t_result        r_pend,       n_pend;
    logic           r_out_valid,  n_out_valid;
    t_result        r_out,        n_out;

    logic           w_mem_we;
    t_slot          w_wslot;
    logic           w_data_full;
    logic           w_store_full;
    logic [15:0]    w_limit;
    logic [15:0]    w_stamped;

    assign w_data_full  = (CMPW'(r_count) >= CMPW'(r_bs)) || w_store_full;
    assign w_store_full = (r_count == CW'(QUEUE_DEPTH));
    assign w_limit      = (r_bs == 8'd0) ? 16'd0 : {8'd0, r_bs - 8'd1};
    assign w_stamped    = (r_rd_slot.remain > w_limit) ? w_limit : r_rd_slot.remain;

    always_comb begin
        w_wslot.tag    = i_cmd.tag;
        w_wslot.ticks  = i_cmd.ticks;
        w_wslot.remain = (i_cmd.kind == OP_FEEDBACK) ? i_cmd.remain : 16'd0;
        w_wslot.fb     = (i_cmd.kind == OP_FEEDBACK);
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_fb_pending = r_fb_pending;
        n_fb_pos     = r_fb_pos;
        n_drop       = r_drop;
        n_busy       = r_busy;
        n_pend       = r_pend;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_res.ready;
        w_mem_we     = 1'b0;
        o_cmd_pop    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_pend    = '0;
                    n_state   = S_EMIT;
                    case (i_cmd.kind)
                        OP_DATA: begin
                            if (w_data_full) begin
                                n_pend.dropped = 1'b1;
                                if (r_drop != '1) begin
                                    n_drop = r_drop + 32'd1;
                                end
                            end else begin
                                w_mem_we = 1'b1;
                                n_tail   = ptr_next(r_tail);
                                n_count  = r_count + 1'b1;
                                if (r_busy == 16'd0) begin
                                    n_state = S_READ;
                                end
                            end
                        end
                        OP_FEEDBACK: begin
                            if (w_store_full) begin
                                n_pend.dropped  = 1'b1;
                                n_pend.overflow = 1'b1;
                            end else begin
                                w_mem_we     = 1'b1;
                                n_tail       = ptr_next(r_tail);
                                n_count      = r_count + 1'b1;
                                n_fb_pending = 1'b1;
                                n_fb_pos     = r_count + 1'b1;
                                if (r_busy == 16'd0) begin
                                    n_state = S_READ;
                                end
                            end
                        end
                        OP_TICK: begin
                            if (r_busy != 16'd0) begin
                                n_busy = r_busy - 16'd1;
                                if (r_busy == 16'd1 && r_count != '0) begin
                                    n_state = S_READ;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_pend.drop_total   = n_drop;
                    n_pend.queue_length = 9'(n_count);
                end
            end
            S_READ: begin
                n_state = S_SERVE;
            end
            S_SERVE: begin
                n_head                  = ptr_next(r_head);
                n_count                 = r_count - 1'b1;
                n_pend                  = '0;
                n_pend.sent             = 1'b1;
                n_pend.sent_tag         = r_rd_slot.tag;
                n_pend.sent_is_feedback = r_rd_slot.fb;
                n_pend.sent_remaining   = r_rd_slot.remain;
                if (r_fb_pending) begin
                    if (r_fb_pos == CW'(1)) begin
                        n_pend.sent_remaining = w_stamped;
                        n_fb_pending          = 1'b0;
                    end
                    if (r_fb_pos != '0) begin
                        n_fb_pos = r_fb_pos - 1'b1;
                    end
                end
                n_busy              = (r_rd_slot.ticks == 16'd0) ? 16'd1 : r_rd_slot.ticks;
                n_pend.drop_total   = r_drop;
                n_pend.queue_length = 9'(n_count);
                n_state             = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Packet store: write on enqueue, registered read of the head.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_tail] <= w_wslot;
        end
        if (r_state == S_READ) begin
            r_rd_slot <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_fb_pending <= 1'b0;
            r_fb_pos     <= '0;
            r_drop       <= '0;
            r_busy       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_fb_pending <= n_fb_pending;
            r_fb_pos     <= n_fb_pos;
            r_drop       <= n_drop;
            r_busy       <= n_busy;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs <= BUFFER_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_bs <= i_cfg_wdata;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.sent             = r_out.sent;
    assign o_res.sent_tag         = r_out.sent_tag;
    assign o_res.sent_is_feedback = r_out.sent_is_feedback;
    assign o_res.sent_remaining   = r_out.sent_remaining;
    assign o_res.dropped          = r_out.dropped;
    assign o_res.overflow         = r_out.overflow;
    assign o_res.drop_total       = r_out.drop_total;
    assign o_res.queue_length     = r_out.queue_length;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds store depth");

    a_fb_pos_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fb_pending |-> (r_fb_pos != '0) && (r_fb_pos <= r_count))
        else $error("tracked feedback position outside occupied entries");

    a_serve_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SERVE) |-> (r_count != '0))
        else $error("serving from an empty store");

    a_read_then_serve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_SERVE))
        else $error("head read not followed by serve");

endmodule
`default_nettype wire

// File: hdl/droptail_queue_feedback_stamp.sv
// Top level of the drop-tail packet queue with feedback stamping.
// Single-server drop-tail packet FIFO. Each request on i_req carries an opcode:
// data arrival, feedback arrival, or one time tick (the unused code changes nothing).
// Every request gives exactly one result on o_res, in order. A data arrival is
// dropped and counted (saturating at all ones) when the queue already holds
// buffer_size entries or the store is full; a feedback arrival is always stored
// unless the store is full, in which case it is flagged as dropped and overflow.
// Only the newest feedback packet is tracked; when it leaves, its remaining-buffer
// field is lowered to min(field, buffer_size - 1). An idle server sends the head
// as soon as something is enqueued, then stays busy for that packet's service
// ticks (zero counts as one) and sends the next packet on the tick that ends the
// count. buffer_size is written through i_cfg_we / i_cfg_wdata, resets to 200,
// and is to be changed only while no request is in flight.
// A request that sends a packet passes an extra read state in the back end, because
// the head is read from the packet store through a registered read port before it
// is served. The front end holds two requests, so i_req keeps taking requests while
// the back end works and while a result waits on o_res, until both entries are full.
// The packet store needs no clearing after reset; the block takes requests at once.
`default_nettype none
module droptail_queue_feedback_stamp #(
    parameter int unsigned QUEUE_DEPTH = dtq_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [7:0]    i_cfg_wdata,
    dtq_req_if.sink            i_req,
    dtq_res_if.source          o_res
);
    import dtq_pkg::*;

    // Request handoff between the front queue and the back sequencer.
    logic  w_cmd_valid;
    t_cmd  w_cmd;
    logic  w_cmd_pop;

    // Accept and classify requests; buffer them so the input side does not wait on the
    // packet store or the result register while a buffer entry is free.
    dtq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Carry out each request: drop or enqueue, advance the server countdown,
    // serve and stamp the head, and hold the result until it is taken.
    dtq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire
